>>> sv/gdda_pkg.sv
// Shared constants, register codes and pipeline record types for the raycast column unit.
package gdda_pkg;

    // Field and datapath widths.
    localparam int COL_W     = 10;
    localparam int POS_W     = 15;
    localparam int VEC_W     = 16;
    localparam int MAP_BITS  = 64;
    localparam int FRAC_W    = 12;
    localparam int FRC_W     = FRAC_W + 1;
    localparam int CAM_NUM_W = COL_W + FRAC_W + 1;
    localparam int CAM_W     = CAM_NUM_W + 1;
    localparam int PROD_W    = VEC_W + CAM_W;
    localparam int RAY_W     = PROD_W - FRAC_W + 1;
    localparam int DLT_NUM_W = 2 * FRAC_W + 1;
    localparam int DLT_W     = 41;
    localparam int SIDE_W    = 46;
    localparam int CELL_W    = 6;
    localparam int DIST_W    = 20;
    localparam int HGT_OUT_W = 9;
    localparam int TOP_OUT_W = 8;
    localparam int BOT_OUT_W = 9;
    localparam int IDX_W     = 3;

    localparam int FRAC_ONE = 4096;

    // Saturated step distance for an axis the ray does not move along.
    localparam logic [DLT_W-1:0] DELTA_SAT = {1'b1, {(DLT_W-1){1'b0}}};
    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};
    localparam logic [DLT_NUM_W-1:0] DLT_NUM = {1'b1, {(DLT_NUM_W-1){1'b0}}};

    // Configuration register indexes.
    localparam logic [IDX_W-1:0] CFG_POS_X   = 3'd0;
    localparam logic [IDX_W-1:0] CFG_POS_Y   = 3'd1;
    localparam logic [IDX_W-1:0] CFG_DIR_X   = 3'd2;
    localparam logic [IDX_W-1:0] CFG_DIR_Y   = 3'd3;
    localparam logic [IDX_W-1:0] CFG_PLANE_X = 3'd4;
    localparam logic [IDX_W-1:0] CFG_PLANE_Y = 3'd5;
    localparam logic [IDX_W-1:0] CFG_BITMAP  = 3'd6;

    // Register reset values: camera at 3.5 cells on both axes looking down the negative first axis.
    localparam logic [POS_W-1:0]    RST_POS_X   = 15'd14336;
    localparam logic [POS_W-1:0]    RST_POS_Y   = 15'd14336;
    localparam logic [VEC_W-1:0]    RST_DIR_X   = 16'hF000;
    localparam logic [VEC_W-1:0]    RST_DIR_Y   = 16'h0000;
    localparam logic [VEC_W-1:0]    RST_PLANE_X = 16'h0000;
    localparam logic [VEC_W-1:0]    RST_PLANE_Y = 16'd2703;
    localparam logic [MAP_BITS-1:0] RST_BITMAP  = 64'hFF818181818181FF;

    // Default geometry.
    localparam int DEF_SCREEN_COLUMNS = 640;
    localparam int DEF_SCREEN_ROWS    = 480;
    localparam int DEF_MAP_ROWS       = 8;
    localparam int DEF_MAP_COLS       = 8;

    // State of one ray as it walks the grid.
    typedef struct packed {
        logic [COL_W-1:0]         col;
        logic [SIDE_W-1:0]        sx;
        logic [SIDE_W-1:0]        sy;
        logic [SIDE_W-1:0]        wdist;
        logic [DLT_W-1:0]         dx;
        logic [DLT_W-1:0]         dy;
        logic                     negx;
        logic                     negy;
        logic signed [CELL_W-1:0] mx;
        logic signed [CELL_W-1:0] my;
        logic                     side;
        logic                     done;
        logic                     hit;
    } t_walk;

    // Walk outcome carried through the height division.
    typedef struct packed {
        logic [COL_W-1:0]  col;
        logic              side;
        logic              hit;
        logic [2:0]        hr;
        logic [2:0]        hc;
        logic [DIST_W-1:0] wdist;
    } t_fin;

endpackage

>>> sv/gdda_div_pipe.sv
// Pipelined restoring divider, one quotient bit per stage, with a tag carried alongside.
module gdda_div_pipe #(
    parameter int NUM_W = 25,
    parameter int DEN_W = 29,
    parameter int TAG_W = 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    input  logic [TAG_W-1:0] i_tag,
    output logic             o_valid,
    output logic [NUM_W-1:0] o_quo,
    output logic [TAG_W-1:0] o_tag
);

    logic             r_vld [NUM_W];
    logic [NUM_W-1:0] r_num [NUM_W];
    logic [NUM_W-1:0] r_quo [NUM_W];
    logic [DEN_W-1:0] r_rem [NUM_W];
    logic [DEN_W-1:0] r_den [NUM_W];
    logic [TAG_W-1:0] r_tag [NUM_W];

    genvar k;
    generate
        for (k = 0; k < NUM_W; k++) begin : g_stage
            logic             s_vld;
            logic [NUM_W-1:0] s_num;
            logic [NUM_W-1:0] s_quo;
            logic [DEN_W-1:0] s_rem;
            logic [DEN_W-1:0] s_den;
            logic [TAG_W-1:0] s_tag;
            logic [DEN_W:0]   s_trial;
            logic [DEN_W:0]   s_diff;
            logic             s_ge;

            // Stage input comes from the ports or from the previous stage.
            if (k == 0) begin : g_in
                assign s_vld = i_valid;
                assign s_num = i_num;
                assign s_quo = '0;
                assign s_rem = '0;
                assign s_den = i_den;
                assign s_tag = i_tag;
            end else begin : g_chain
                assign s_vld = r_vld[k-1];
                assign s_num = r_num[k-1];
                assign s_quo = r_quo[k-1];
                assign s_rem = r_rem[k-1];
                assign s_den = r_den[k-1];
                assign s_tag = r_tag[k-1];
            end

            // Shift in the next numerator bit and try one subtraction.
            assign s_trial = {s_rem, s_num[NUM_W-1]};
            assign s_diff  = s_trial - {1'b0, s_den};
            assign s_ge    = (s_trial >= {1'b0, s_den});

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[k] <= 1'b0;
                end else begin
                    r_vld[k] <= s_vld;
                end
            end

            always_ff @(posedge i_clk) begin
                r_num[k] <= {s_num[NUM_W-2:0], 1'b0};
                r_quo[k] <= {s_quo[NUM_W-2:0], s_ge};
                r_rem[k] <= s_ge ? s_diff[DEN_W-1:0] : s_trial[DEN_W-1:0];
                r_den[k] <= s_den;
                r_tag[k] <= s_tag;
            end
        end
    endgenerate

    assign o_valid = r_vld[NUM_W-1];
    assign o_quo   = r_quo[NUM_W-1];
    assign o_tag   = r_tag[NUM_W-1];

endmodule

>>> sv/gdda_walk_stage.sv
// One registered grid step of the ray walk: advance one axis and test the new cell.
module gdda_walk_stage #(
    parameter int MAP_ROWS = gdda_pkg::DEF_MAP_ROWS,
    parameter int MAP_COLS = gdda_pkg::DEF_MAP_COLS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_vld,
    input  gdda_pkg::t_walk               i_walk,
    input  logic [gdda_pkg::MAP_BITS-1:0] i_bitmap,
    output logic                          o_vld,
    output gdda_pkg::t_walk               o_walk
);

    localparam logic signed [gdda_pkg::CELL_W-1:0] ROW_LIM = gdda_pkg::CELL_W'(MAP_ROWS);
    localparam logic signed [gdda_pkg::CELL_W-1:0] COL_LIM = gdda_pkg::CELL_W'(MAP_COLS);

    gdda_pkg::t_walk n_walk;
    logic            w_out;
    logic            r_vld;
    gdda_pkg::t_walk r_walk;

    // Step along the axis with the smaller side value; ties go to the second axis.
    always_comb begin
        n_walk = i_walk;
        w_out  = 1'b0;
        if (!i_walk.done) begin
            if (i_walk.sx < i_walk.sy) begin
                n_walk.wdist = i_walk.sx;
                n_walk.sx    = i_walk.sx + gdda_pkg::SIDE_W'(i_walk.dx);
                n_walk.mx    = i_walk.negx ? i_walk.mx - 6'sd1 : i_walk.mx + 6'sd1;
                n_walk.side  = 1'b0;
            end else begin
                n_walk.wdist = i_walk.sy;
                n_walk.sy    = i_walk.sy + gdda_pkg::SIDE_W'(i_walk.dy);
                n_walk.my    = i_walk.negy ? i_walk.my - 6'sd1 : i_walk.my + 6'sd1;
                n_walk.side  = 1'b1;
            end
            w_out = (n_walk.mx < 6'sd0) || (n_walk.mx >= ROW_LIM) ||
                    (n_walk.my < 6'sd0) || (n_walk.my >= COL_LIM);
            if (w_out) begin
                n_walk.done = 1'b1;
                n_walk.hit  = 1'b0;
            end else if (i_bitmap[{n_walk.mx[2:0], n_walk.my[2:0]}]) begin
                n_walk.done = 1'b1;
                n_walk.hit  = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_walk <= n_walk;
    end

    assign o_vld  = r_vld;
    assign o_walk = r_walk;

endmodule

>>> sv/grid_dda_raycast_column_unit.sv
// Top level of the raycast column unit: camera registers, ray setup, grid walk and slice math.
//
// One screen column is taken in every clock cycle and passes in order through the camera
// coordinate reciprocal multiply, the ray multiply, add and magnitude registers, the step
// distance dividers, the start side values, one register per grid step, the distance clamp,
// the height divider and the output register. The pipeline never stalls, so busy stays low
// and every result is shown for exactly one cycle on o_valid; results leave in the order
// their columns came in. Configuration writes are always accepted and must only be issued
// while no column is in flight.
module grid_dda_raycast_column_unit #(
    parameter int SCREEN_COLUMNS = gdda_pkg::DEF_SCREEN_COLUMNS,
    parameter int SCREEN_ROWS    = gdda_pkg::DEF_SCREEN_ROWS,
    parameter int MAP_ROWS       = gdda_pkg::DEF_MAP_ROWS,
    parameter int MAP_COLS       = gdda_pkg::DEF_MAP_COLS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [gdda_pkg::COL_W-1:0]    i_column,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [gdda_pkg::IDX_W-1:0]    i_cfg_index,
    input  logic [gdda_pkg::MAP_BITS-1:0] i_cfg_data,
    output logic                          o_valid,
    output logic [gdda_pkg::COL_W-1:0]    o_column_out,
    output logic [gdda_pkg::HGT_OUT_W-1:0] o_slice_height,
    output logic [gdda_pkg::TOP_OUT_W-1:0] o_slice_top,
    output logic [gdda_pkg::BOT_OUT_W-1:0] o_slice_bottom,
    output logic                          o_hit_side,
    output logic [gdda_pkg::DIST_W-1:0]   o_wall_distance,
    output logic [2:0]                    o_hit_row,
    output logic [2:0]                    o_hit_col,
    output logic                          o_escaped
);

    localparam int HN_W   = $clog2(SCREEN_ROWS * gdda_pkg::FRAC_ONE + 1);
    localparam int HGT_W  = $clog2(SCREEN_ROWS + 1);
    localparam int NSTEP  = MAP_ROWS + MAP_COLS + 2;
    localparam int FIN_W  = $bits(gdda_pkg::t_fin);
    localparam int TAGX_W = gdda_pkg::COL_W + 2;
    localparam logic [HGT_W:0] ROWS_V = (HGT_W + 1)'(SCREEN_ROWS);

    // Reciprocal of the screen width: with l = clog2(SCREEN_COLUMNS) and
    // m = ceil(2^(23+l) / SCREEN_COLUMNS), column * m shifted right by 10 + l
    // is the exact floor of column * 8192 / SCREEN_COLUMNS for every 10-bit column.
    localparam int     CD_L  = $clog2(SCREEN_COLUMNS);
    localparam int     CD_SH = gdda_pkg::COL_W + CD_L;
    localparam int     CDM_W = gdda_pkg::CAM_NUM_W + 1;
    localparam int     CDP_W = gdda_pkg::COL_W + CDM_W;
    localparam longint CD_M  = ((longint'(1) <<< (gdda_pkg::CAM_NUM_W + CD_L))
                               + longint'(SCREEN_COLUMNS) - 1) / longint'(SCREEN_COLUMNS);
    localparam logic [CDM_W-1:0] CD_M_V = CDM_W'(CD_M);

    // Camera and map registers.
    logic [gdda_pkg::POS_W-1:0]    r_pos_x;
    logic [gdda_pkg::POS_W-1:0]    r_pos_y;
    logic [gdda_pkg::VEC_W-1:0]    r_dir_x;
    logic [gdda_pkg::VEC_W-1:0]    r_dir_y;
    logic [gdda_pkg::VEC_W-1:0]    r_plane_x;
    logic [gdda_pkg::VEC_W-1:0]    r_plane_y;
    logic [gdda_pkg::MAP_BITS-1:0] r_bitmap;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x   <= gdda_pkg::RST_POS_X;
            r_pos_y   <= gdda_pkg::RST_POS_Y;
            r_dir_x   <= gdda_pkg::RST_DIR_X;
            r_dir_y   <= gdda_pkg::RST_DIR_Y;
            r_plane_x <= gdda_pkg::RST_PLANE_X;
            r_plane_y <= gdda_pkg::RST_PLANE_Y;
            r_bitmap  <= gdda_pkg::RST_BITMAP;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                gdda_pkg::CFG_POS_X:   r_pos_x   <= i_cfg_data[gdda_pkg::POS_W-1:0];
                gdda_pkg::CFG_POS_Y:   r_pos_y   <= i_cfg_data[gdda_pkg::POS_W-1:0];
                gdda_pkg::CFG_DIR_X:   r_dir_x   <= i_cfg_data[gdda_pkg::VEC_W-1:0];
                gdda_pkg::CFG_DIR_Y:   r_dir_y   <= i_cfg_data[gdda_pkg::VEC_W-1:0];
                gdda_pkg::CFG_PLANE_X: r_plane_x <= i_cfg_data[gdda_pkg::VEC_W-1:0];
                gdda_pkg::CFG_PLANE_Y: r_plane_y <= i_cfg_data[gdda_pkg::VEC_W-1:0];
                gdda_pkg::CFG_BITMAP:  r_bitmap  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Camera coordinate: column * 8192 / SCREEN_COLUMNS by a constant multiply and shift.
    logic [CDP_W-1:0]               w_cam_prod;
    logic                           r_c_vld;
    logic [gdda_pkg::COL_W-1:0]     r_c_col;
    logic [gdda_pkg::CAM_NUM_W-1:0] r_c_q;

    assign w_cam_prod = CDP_W'(i_column) * CDP_W'(CD_M_V);

    always_ff @(posedge i_clk) begin
        r_c_col <= i_column;
        r_c_q   <= gdda_pkg::CAM_NUM_W'(w_cam_prod >> CD_SH);
    end

    // Plane times camera coordinate.
    logic signed [gdda_pkg::CAM_W-1:0]  w_cam;
    logic                               r_m_vld;
    logic [gdda_pkg::COL_W-1:0]         r_m_col;
    logic signed [gdda_pkg::PROD_W-1:0] r_px;
    logic signed [gdda_pkg::PROD_W-1:0] r_py;

    assign w_cam = $signed({1'b0, r_c_q}) - $signed(gdda_pkg::CAM_W'(gdda_pkg::FRAC_ONE));

    always_ff @(posedge i_clk) begin
        r_m_col <= r_c_col;
        r_px    <= $signed(r_plane_x) * w_cam;
        r_py    <= $signed(r_plane_y) * w_cam;
    end

    // Ray direction: view direction plus the floored plane offset.
    logic                              r_r_vld;
    logic [gdda_pkg::COL_W-1:0]        r_r_col;
    logic signed [gdda_pkg::RAY_W-1:0] r_rx;
    logic signed [gdda_pkg::RAY_W-1:0] r_ry;

    always_ff @(posedge i_clk) begin
        r_r_col <= r_m_col;
        r_rx    <= gdda_pkg::RAY_W'($signed(r_dir_x) + (r_px >>> gdda_pkg::FRAC_W));
        r_ry    <= gdda_pkg::RAY_W'($signed(r_dir_y) + (r_py >>> gdda_pkg::FRAC_W));
    end

    // Ray magnitudes and signs for the step distance division.
    logic                       r_a_vld;
    logic [gdda_pkg::COL_W-1:0] r_a_col;
    logic [gdda_pkg::RAY_W-1:0] r_ax;
    logic [gdda_pkg::RAY_W-1:0] r_ay;
    logic                       r_nx;
    logic                       r_ny;
    logic                       r_zx;
    logic                       r_zy;

    always_ff @(posedge i_clk) begin
        r_a_col <= r_r_col;
        r_ax    <= r_rx[gdda_pkg::RAY_W-1] ? gdda_pkg::RAY_W'(-r_rx) : gdda_pkg::RAY_W'(r_rx);
        r_ay    <= r_ry[gdda_pkg::RAY_W-1] ? gdda_pkg::RAY_W'(-r_ry) : gdda_pkg::RAY_W'(r_ry);
        r_nx    <= r_rx[gdda_pkg::RAY_W-1];
        r_ny    <= r_ry[gdda_pkg::RAY_W-1];
        r_zx    <= (r_rx == '0);
        r_zy    <= (r_ry == '0);
    end

    // Front-end valid chain.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
            r_m_vld <= 1'b0;
            r_r_vld <= 1'b0;
            r_a_vld <= 1'b0;
        end else begin
            r_c_vld <= start;
            r_m_vld <= r_c_vld;
            r_r_vld <= r_m_vld;
            r_a_vld <= r_r_vld;
        end
    end

    // Step distances: 2^24 / |ray| per axis.
    logic                           w_dvx_vld;
    logic                           w_dvy_vld;
    logic [gdda_pkg::DLT_NUM_W-1:0] w_qx;
    logic [gdda_pkg::DLT_NUM_W-1:0] w_qy;
    logic [TAGX_W-1:0]              w_tagx;
    logic [1:0]                     w_tagy;

    gdda_div_pipe #(
        .NUM_W(gdda_pkg::DLT_NUM_W),
        .DEN_W(gdda_pkg::RAY_W),
        .TAG_W(TAGX_W)
    ) u_dx_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(r_a_vld),
        .i_num  (gdda_pkg::DLT_NUM),
        .i_den  (r_ax),
        .i_tag  ({r_a_col, r_nx, r_zx}),
        .o_valid(w_dvx_vld),
        .o_quo  (w_qx),
        .o_tag  (w_tagx)
    );

    gdda_div_pipe #(
        .NUM_W(gdda_pkg::DLT_NUM_W),
        .DEN_W(gdda_pkg::RAY_W),
        .TAG_W(2)
    ) u_dy_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(r_a_vld),
        .i_num  (gdda_pkg::DLT_NUM),
        .i_den  (r_ay),
        .i_tag  ({r_ny, r_zy}),
        .o_valid(w_dvy_vld),
        .o_quo  (w_qy),
        .o_tag  (w_tagy)
    );

    // Starting side values from the fractional position and the step distance.
    logic [gdda_pkg::DLT_W-1:0]              w_dx;
    logic [gdda_pkg::DLT_W-1:0]              w_dy;
    logic [gdda_pkg::FRC_W-1:0]              w_fx;
    logic [gdda_pkg::FRC_W-1:0]              w_fy;
    logic [gdda_pkg::FRC_W+gdda_pkg::DLT_W-1:0] w_prx;
    logic [gdda_pkg::FRC_W+gdda_pkg::DLT_W-1:0] w_pry;
    logic                                    r_s_vld;
    gdda_pkg::t_walk                         r_s_walk;

    assign w_dx = w_tagx[0] ? gdda_pkg::DELTA_SAT : gdda_pkg::DLT_W'(w_qx);
    assign w_dy = w_tagy[0] ? gdda_pkg::DELTA_SAT : gdda_pkg::DLT_W'(w_qy);
    assign w_fx = w_tagx[1] ? {1'b0, r_pos_x[gdda_pkg::FRAC_W-1:0]}
                            : gdda_pkg::FRC_W'(gdda_pkg::FRAC_ONE)
                              - {1'b0, r_pos_x[gdda_pkg::FRAC_W-1:0]};
    assign w_fy = w_tagy[1] ? {1'b0, r_pos_y[gdda_pkg::FRAC_W-1:0]}
                            : gdda_pkg::FRC_W'(gdda_pkg::FRAC_ONE)
                              - {1'b0, r_pos_y[gdda_pkg::FRAC_W-1:0]};
    assign w_prx = w_fx * w_dx;
    assign w_pry = w_fy * w_dy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_vld <= 1'b0;
        end else begin
            r_s_vld <= w_dvx_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s_walk.col   <= w_tagx[TAGX_W-1:2];
        r_s_walk.sx    <= gdda_pkg::SIDE_W'(w_prx[gdda_pkg::FRC_W+gdda_pkg::DLT_W-1:gdda_pkg::FRAC_W]);
        r_s_walk.sy    <= gdda_pkg::SIDE_W'(w_pry[gdda_pkg::FRC_W+gdda_pkg::DLT_W-1:gdda_pkg::FRAC_W]);
        r_s_walk.wdist <= '0;
        r_s_walk.dx    <= w_dx;
        r_s_walk.dy    <= w_dy;
        r_s_walk.negx  <= w_tagx[1];
        r_s_walk.negy  <= w_tagy[1];
        r_s_walk.mx    <= $signed({3'b000, r_pos_x[gdda_pkg::POS_W-1:gdda_pkg::FRAC_W]});
        r_s_walk.my    <= $signed({3'b000, r_pos_y[gdda_pkg::POS_W-1:gdda_pkg::FRAC_W]});
        r_s_walk.side  <= 1'b0;
        r_s_walk.done  <= 1'b0;
        r_s_walk.hit   <= 1'b0;
    end

    // Grid walk, one registered step per stage.
    logic            w_wvld  [NSTEP+1];
    gdda_pkg::t_walk w_walk  [NSTEP+1];

    assign w_wvld[0] = r_s_vld;
    assign w_walk[0] = r_s_walk;

    genvar s;
    generate
        for (s = 0; s < NSTEP; s++) begin : g_walk
            gdda_walk_stage #(
                .MAP_ROWS(MAP_ROWS),
                .MAP_COLS(MAP_COLS)
            ) u_step (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_vld   (w_wvld[s]),
                .i_walk  (w_walk[s]),
                .i_bitmap(r_bitmap),
                .o_vld   (w_wvld[s+1]),
                .o_walk  (w_walk[s+1])
            );
        end
    endgenerate

    // Clamp the distance and settle the escape case.
    gdda_pkg::t_walk w_last;
    logic            r_f_vld;
    gdda_pkg::t_fin  r_fin;

    assign w_last = w_walk[NSTEP];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_vld <= 1'b0;
        end else begin
            r_f_vld <= w_wvld[NSTEP];
        end
    end

    always_ff @(posedge i_clk) begin
        r_fin.col  <= w_last.col;
        r_fin.hit  <= w_last.hit;
        r_fin.side <= w_last.hit & w_last.side;
        r_fin.hr   <= w_last.hit ? w_last.mx[2:0] : 3'd0;
        r_fin.hc   <= w_last.hit ? w_last.my[2:0] : 3'd0;
        if (!w_last.hit || w_last.wdist > gdda_pkg::SIDE_W'(gdda_pkg::DIST_MAX)) begin
            r_fin.wdist <= gdda_pkg::DIST_MAX;
        end else begin
            r_fin.wdist <= w_last.wdist[gdda_pkg::DIST_W-1:0];
        end
    end

    // Slice height: SCREEN_ROWS * 4096 / distance.
    logic             w_h_vld;
    logic [HN_W-1:0]  w_hq;
    logic [FIN_W-1:0] w_htag;

    gdda_div_pipe #(
        .NUM_W(HN_W),
        .DEN_W(gdda_pkg::DIST_W),
        .TAG_W(FIN_W)
    ) u_h_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(r_f_vld),
        .i_num  (HN_W'(SCREEN_ROWS * gdda_pkg::FRAC_ONE)),
        .i_den  (r_fin.wdist),
        .i_tag  (r_fin),
        .o_valid(w_h_vld),
        .o_quo  (w_hq),
        .o_tag  (w_htag)
    );

    // Clamp the height and place the slice around the screen center.
    gdda_pkg::t_fin w_fo;
    logic [HGT_W:0] w_h;
    logic [HGT_W:0] w_top;
    logic [HGT_W:0] w_bot;

    assign w_fo = w_htag;

    always_comb begin
        if (!w_fo.hit) begin
            w_h = '0;
        end else if (w_hq > HN_W'(SCREEN_ROWS)) begin
            w_h = ROWS_V;
        end else begin
            w_h = (HGT_W + 1)'(w_hq);
        end
        w_top = (ROWS_V - w_h) >> 1;
        w_bot = (ROWS_V + w_h) >> 1;
    end

    logic r_o_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else begin
            r_o_vld <= w_h_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        o_column_out    <= w_fo.col;
        o_slice_height  <= gdda_pkg::HGT_OUT_W'(w_h);
        o_slice_top     <= gdda_pkg::TOP_OUT_W'(w_top);
        o_slice_bottom  <= gdda_pkg::BOT_OUT_W'(w_bot);
        o_hit_side      <= w_fo.side;
        o_wall_distance <= w_fo.wdist;
        o_hit_row       <= w_fo.hr;
        o_hit_col       <= w_fo.hc;
        o_escaped       <= ~w_fo.hit;
    end

    assign o_valid = r_o_vld;

`ifndef ASSERT_OFF
    // The two step distance dividers run in lockstep.
    a_delta_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_dvx_vld == w_dvy_vld)
        else $error("step distance dividers out of step");

    // An escaped ray reports no slice and the saturated distance.
    a_escape_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_escaped |-> o_slice_height == '0 &&
        o_wall_distance == gdda_pkg::DIST_MAX && !o_hit_side)
        else $error("escaped ray with wall data");

    // A hit cell always lies inside the map.
    a_hit_in_map: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_escaped |-> (32'(o_hit_row) < MAP_ROWS) && (32'(o_hit_col) < MAP_COLS))
        else $error("hit cell outside the map");

    // A valid height division gives a valid result in the next cycle.
    a_out_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_h_vld |=> o_valid)
        else $error("result lost at output register");
`endif

endmodule
